// ----- sv/lgts_pkg.sv -----
// Shared types and constants for the LDA Gibbs topic sampler.
// Holds the payload structs, the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lgts_pkg;

	localparam int MAX_TOPICS = 16;
	localparam int TOPIC_BITS = 4;
	localparam int KN_BITS    = 5;
	localparam int DOC_BITS   = 10;
	localparam int WORD_BITS  = 12;
	localparam int COUNT_BITS = 16;
	localparam int TOTAL_BITS = 24;
	localparam int RND_BITS   = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 32;
	localparam int DEN_BITS   = 41;
	localparam int REM_BITS   = 42;
	localparam int PROD_BITS  = 66;
	localparam int SUM_BITS   = 36;
	localparam int CLR_BITS   = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_TOPICS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_PRIOR   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BETA_PRIOR    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BETA_TOTAL    = 2'd3;

	typedef struct packed {
		logic                  opcode;
		logic [DOC_BITS-1:0]   doc_index;
		logic [WORD_BITS-1:0]  word_index;
		logic [TOPIC_BITS-1:0] current_topic;
		logic [RND_BITS-1:0]   random_fraction;
	} in_item_t;

	typedef struct packed {
		logic [TOPIC_BITS-1:0] new_topic;
		logic                  count_error;
	} out_item_t;

	// Which topic addresses the count tables.
	typedef enum logic [1:0] {
		TSEL_CUR,
		TSEL_LOOP,
		TSEL_CHOSEN
	} tsel_t;

	typedef struct packed {
		logic                  load;
		logic                  clr_step;
		tsel_t                 tsel;
		logic [TOPIC_BITS-1:0] k;
		logic                  mem_rd;
		logic                  dec_wr;
		logic                  inc_wr;
		logic                  form;
		logic                  mul;
		logic                  acc;
		logic [1:0]            pp_idx;
		logic                  div_init;
		logic                  div_step;
		logic [4:0]            div_bit;
		logic                  wacc;
		logic                  thr;
		logic                  pick;
		logic                  out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic opcode;
		logic k_last;
		logic hit;
	} sts_t;

endpackage

`default_nettype wire

// ----- sv/lgts_dp.sv -----
// Datapath of the topic sampler: count memories, topic totals, weight
// multiplier, restoring divider, cumulative weights and the draw.
// Depends on lgts_pkg.
`default_nettype none

module lgts_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire lgts_pkg::cmd_t                     cmd,
	output lgts_pkg::sts_t                          sts,
	input  wire lgts_pkg::in_item_t                 in_data,
	output lgts_pkg::out_item_t                     out_data,
	input  wire logic                               cfg_we,
	input  wire logic [lgts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [lgts_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam logic [lgts_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [lgts_pkg::TOTAL_BITS-1:0] TOTAL_MAX = '1;

	logic [4:0]  active_q;
	logic [19:0] alpha_q;
	logic [19:0] beta_q;
	logic [31:0] beta_total_q;

	lgts_pkg::in_item_t item_q;
	logic [lgts_pkg::KN_BITS-1:0]    kn_q;
	logic [lgts_pkg::TOPIC_BITS-1:0] t_q;
	logic [lgts_pkg::TOPIC_BITS-1:0] chosen_q;
	logic                            err_q;

	logic [lgts_pkg::CLR_BITS-1:0] clr_q;

	logic [lgts_pkg::COUNT_BITS-1:0] doc_mem [0:16383];
	logic [lgts_pkg::COUNT_BITS-1:0] word_mem [0:65535];
	logic [lgts_pkg::COUNT_BITS-1:0] doc_rd_q;
	logic [lgts_pkg::COUNT_BITS-1:0] word_rd_q;
	logic [lgts_pkg::TOTAL_BITS-1:0] totals_q [0:lgts_pkg::MAX_TOPICS-1];

	logic [lgts_pkg::COUNT_BITS-1:0] c1_q;
	logic [lgts_pkg::COUNT_BITS-1:0] c2_q;
	logic [lgts_pkg::DEN_BITS-1:0]   den_q;
	logic [39:0]                     prod_q;
	logic [lgts_pkg::PROD_BITS-1:0]  acc_q;
	logic [lgts_pkg::REM_BITS-1:0]   rem_q;
	logic [31:0]                     quo_q;
	logic                            den_zero_q;
	logic                            sat_q;
	logic [lgts_pkg::SUM_BITS-1:0]   sum_q;
	logic [lgts_pkg::SUM_BITS-1:0]   cdf_q [0:lgts_pkg::MAX_TOPICS-1];
	logic [lgts_pkg::SUM_BITS-1:0]   thr_q;

	logic [lgts_pkg::TOPIC_BITS-1:0] topic;
	logic [13:0]                     doc_addr;
	logic [15:0]                     word_addr;
	logic [lgts_pkg::TOTAL_BITS-1:0] total_cur;
	logic [lgts_pkg::KN_BITS-1:0]    kn_new;
	logic [19:0]                     ma;
	logic [19:0]                     mb;
	logic [lgts_pkg::REM_BITS-1:0]   r2;
	logic [31:0]                     w;
	logic [51:0]                     thr_prod;
	logic [lgts_pkg::SUM_BITS-1:0]   sum_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 5'd16;
			alpha_q      <= 20'd6554;
			beta_q       <= 20'd655;
			beta_total_q <= 32'd2682880;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lgts_pkg::CFG_ACTIVE_TOPICS: active_q     <= cfg_data[4:0];
				lgts_pkg::CFG_ALPHA_PRIOR:   alpha_q      <= cfg_data[19:0];
				lgts_pkg::CFG_BETA_PRIOR:    beta_q       <= cfg_data[19:0];
				lgts_pkg::CFG_BETA_TOTAL:    beta_total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Active topic count, clamped to the built range.
	always_comb begin
		if (active_q == '0) begin
			kn_new = lgts_pkg::KN_BITS'(1);
		end else if (active_q > lgts_pkg::KN_BITS'(lgts_pkg::MAX_TOPICS)) begin
			kn_new = lgts_pkg::KN_BITS'(lgts_pkg::MAX_TOPICS);
		end else begin
			kn_new = active_q;
		end
	end

	// Topic that addresses the tables this cycle.
	always_comb begin
		case (cmd.tsel)
			lgts_pkg::TSEL_CUR:    topic = t_q;
			lgts_pkg::TSEL_LOOP:   topic = cmd.k;
			lgts_pkg::TSEL_CHOSEN: topic = chosen_q;
			default:               topic = t_q;
		endcase
	end

	assign doc_addr  = {item_q.doc_index, topic};
	assign word_addr = {item_q.word_index, topic};
	assign total_cur = totals_q[topic];

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !(&clr_q)) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Document-topic count memory.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			doc_mem[clr_q[13:0]] <= '0;
		end else if (cmd.dec_wr) begin
			doc_mem[doc_addr] <= (doc_rd_q == '0) ? '0 : doc_rd_q - 1'b1;
		end else if (cmd.inc_wr) begin
			doc_mem[doc_addr] <= (doc_rd_q == COUNT_MAX) ? COUNT_MAX : doc_rd_q + 1'b1;
		end
		if (cmd.mem_rd) begin
			doc_rd_q <= doc_mem[doc_addr];
		end
	end

	// Word-topic count memory.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			word_mem[clr_q] <= '0;
		end else if (cmd.dec_wr) begin
			word_mem[word_addr] <= (word_rd_q == '0) ? '0 : word_rd_q - 1'b1;
		end else if (cmd.inc_wr) begin
			word_mem[word_addr] <= (word_rd_q == COUNT_MAX) ? COUNT_MAX : word_rd_q + 1'b1;
		end
		if (cmd.mem_rd) begin
			word_rd_q <= word_mem[word_addr];
		end
	end

	// Topic totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lgts_pkg::MAX_TOPICS; i++) begin
				totals_q[i] <= '0;
			end
		end else if (cmd.dec_wr) begin
			totals_q[topic] <= (total_cur == '0) ? '0 : total_cur - 1'b1;
		end else if (cmd.inc_wr) begin
			totals_q[topic] <= (total_cur == TOTAL_MAX) ? TOTAL_MAX : total_cur + 1'b1;
		end
	end

	// Item capture and error flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (cmd.load) begin
			err_q <= 1'b0;
		end else begin
			if (cmd.dec_wr && (doc_rd_q == '0 || word_rd_q == '0 || total_cur == '0)) begin
				err_q <= 1'b1;
			end
			if (cmd.inc_wr && (doc_rd_q == COUNT_MAX || word_rd_q == COUNT_MAX
					|| total_cur == TOTAL_MAX)) begin
				err_q <= 1'b1;
			end
			if (cmd.wacc && (den_zero_q || sat_q)) begin
				err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			kn_q   <= kn_new;
			if (lgts_pkg::KN_BITS'(in_data.current_topic) >= kn_new) begin
				t_q <= lgts_pkg::TOPIC_BITS'(kn_new - 1'b1);
			end else begin
				t_q <= in_data.current_topic;
			end
		end
		if (cmd.pick) begin
			chosen_q <= topic;
		end
	end

	// Weight factors and denominator.
	always_comb begin
		case (cmd.pp_idx)
			2'd0:    begin ma = 20'(c1_q); mb = 20'(c2_q); end
			2'd1:    begin ma = 20'(c1_q); mb = beta_q;    end
			2'd2:    begin ma = 20'(c2_q); mb = alpha_q;   end
			default: begin ma = alpha_q;   mb = beta_q;    end
		endcase
	end

	assign r2 = {rem_q[lgts_pkg::REM_BITS-2:0], acc_q[cmd.div_bit]};
	assign w  = den_zero_q ? 32'd0 : (sat_q ? 32'hFFFF_FFFF : quo_q);
	assign sum_next = sum_q + lgts_pkg::SUM_BITS'(w);
	assign thr_prod = 52'(item_q.random_fraction) * 52'(sum_q);

	always_ff @(posedge clk) begin
		if (cmd.form) begin
			c1_q  <= doc_rd_q;
			c2_q  <= word_rd_q;
			den_q <= lgts_pkg::DEN_BITS'({total_cur, 16'h0000})
				+ lgts_pkg::DEN_BITS'(beta_total_q);
			acc_q <= '0;
		end
		// Product of the two Q.16 factors as four partial products.
		if (cmd.mul) begin
			prod_q <= 40'(ma) * 40'(mb);
		end
		if (cmd.acc) begin
			case (cmd.pp_idx)
				2'd0:    acc_q <= acc_q + (lgts_pkg::PROD_BITS'(prod_q) << 32);
				2'd1,
				2'd2:    acc_q <= acc_q + (lgts_pkg::PROD_BITS'(prod_q) << 16);
				default: acc_q <= acc_q + lgts_pkg::PROD_BITS'(prod_q);
			endcase
		end
		// Restoring division, one quotient bit per cycle.
		if (cmd.div_init) begin
			rem_q      <= lgts_pkg::REM_BITS'(acc_q[65:32]);
			quo_q      <= '0;
			den_zero_q <= (den_q == '0);
			sat_q      <= lgts_pkg::REM_BITS'(acc_q[65:32]) >= lgts_pkg::REM_BITS'(den_q);
		end
		if (cmd.div_step) begin
			if (r2 >= lgts_pkg::REM_BITS'(den_q)) begin
				rem_q <= r2 - lgts_pkg::REM_BITS'(den_q);
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= r2;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		// Running sum and cumulative weights.
		if (cmd.load) begin
			sum_q <= '0;
		end else if (cmd.wacc) begin
			sum_q        <= sum_next;
			cdf_q[cmd.k] <= sum_next;
		end
		if (cmd.thr) begin
			thr_q <= thr_prod[51:16];
		end
		if (cmd.out_load) begin
			out_data.new_topic   <= chosen_q;
			out_data.count_error <= err_q;
		end
	end

	assign sts.clr_done = &clr_q;
	assign sts.opcode   = item_q.opcode;
	assign sts.k_last   = (lgts_pkg::KN_BITS'(cmd.k) == kn_q - 1'b1);
	assign sts.hit      = (thr_q <= cdf_q[cmd.k]);

endmodule

`default_nettype wire

// ----- sv/lgts_ctrl.sv -----
// Controller of the topic sampler: sequences clearing, removal, weighing,
// the draw, adding or re-adding and the output handshake.
// Depends on lgts_pkg.
`default_nettype none

module lgts_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output lgts_pkg::cmd_t      cmd,
	input  wire lgts_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_START, S_RD_CUR, S_DEC, S_RD_K, S_FORM, S_MUL,
		S_ACC, S_DIV_INIT, S_DIV, S_WACC, S_THR, S_SCAN, S_ADD_RD, S_DONE
	} state_t;

	state_t                          state_q;
	logic [lgts_pkg::TOPIC_BITS-1:0] k_q;
	logic [1:0]                      pp_q;
	logic [4:0]                      bit_q;
	logic                            out_valid_q;
	logic                            add_wr_q;
	logic                            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd          = '0;
		cmd.tsel     = lgts_pkg::TSEL_LOOP;
		cmd.k        = k_q;
		cmd.pp_idx   = pp_q;
		cmd.div_bit  = bit_q;
		unique case (state_q)
			S_CLEAR:    cmd.clr_step = 1'b1;
			S_IDLE:     cmd.load = in_valid;
			S_START: begin
				cmd.tsel = lgts_pkg::TSEL_CUR;
				cmd.pick = !sts.opcode;
			end
			S_RD_CUR: begin
				cmd.tsel   = lgts_pkg::TSEL_CUR;
				cmd.mem_rd = 1'b1;
			end
			S_DEC: begin
				cmd.tsel   = lgts_pkg::TSEL_CUR;
				cmd.dec_wr = 1'b1;
			end
			S_RD_K:     cmd.mem_rd = 1'b1;
			S_FORM:     cmd.form = 1'b1;
			S_MUL:      cmd.mul = 1'b1;
			S_ACC:      cmd.acc = 1'b1;
			S_DIV_INIT: cmd.div_init = 1'b1;
			S_DIV:      cmd.div_step = 1'b1;
			S_WACC:     cmd.wacc = 1'b1;
			S_THR:      cmd.thr = 1'b1;
			S_SCAN:     cmd.pick = sts.hit || sts.k_last;
			S_ADD_RD: begin
				cmd.tsel   = lgts_pkg::TSEL_CHOSEN;
				cmd.mem_rd = !add_wr_q;
				cmd.inc_wr = add_wr_q;
			end
			S_DONE:     cmd.out_load = out_free;
			default: ;
		endcase
	end

	// State, counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			k_q         <= '0;
			pp_q        <= '0;
			bit_q       <= '0;
			add_wr_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output flag rises when a result is registered and falls on its transaction.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					k_q      <= '0;
					add_wr_q <= 1'b0;
					state_q  <= sts.opcode ? S_RD_CUR : S_ADD_RD;
				end
				S_RD_CUR:   state_q <= S_DEC;
				S_DEC:      state_q <= S_RD_K;
				S_RD_K:     state_q <= S_FORM;
				S_FORM: begin
					pp_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL:      state_q <= S_ACC;
				S_ACC: begin
					pp_q <= pp_q + 1'b1;
					state_q <= (pp_q == 2'd3) ? S_DIV_INIT : S_MUL;
				end
				S_DIV_INIT: begin
					bit_q   <= 5'd31;
					state_q <= S_DIV;
				end
				S_DIV: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= S_WACC;
					end
				end
				S_WACC: begin
					if (sts.k_last) begin
						k_q     <= '0;
						state_q <= S_THR;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RD_K;
					end
				end
				S_THR:      state_q <= S_SCAN;
				S_SCAN: begin
					if (sts.hit || sts.k_last) begin
						add_wr_q <= 1'b0;
						state_q  <= S_ADD_RD;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_ADD_RD: begin
					add_wr_q <= !add_wr_q;
					if (add_wr_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/lda_gibbs_topic_sampler.sv -----
// Top level of the LDA collapsed Gibbs topic sampler.
// Joins lgts_ctrl and lgts_dp; depends on lgts_pkg.
//
// Usage:
//  Tokens arrive on the in channel (valid/ready) as one in_item_t transaction.
//  Opcode 0 adds the token under its initial topic; opcode 1 removes it,
//  weighs every active topic, draws a new topic and re-adds the token.
//  Each token yields one out_item_t transaction on the out channel.
//  An add reads and increments the counts of its topic, then registers the result.
//  A resample removes the token; for each of the K active topics it does a memory
//  read, four partial products through one 20x20 multiplier and 32 steps of the
//  one-bit-per-cycle divider; then it draws a topic and re-adds the token. in_ready
//  rises in the cycle after the result reaches the output register.
//  A result waiting on out_ready does not block the next token until that
//  one is done too.
//  After reset the count memories are swept to zero, one entry a cycle, over all
//  65536 word-table addresses; in_ready stays low meanwhile. Configuration writes
//  through cfg_we/cfg_index/cfg_data are taken at any time but are meant
//  for idle periods.
`default_nettype none

module lda_gibbs_topic_sampler (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire lgts_pkg::in_item_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output lgts_pkg::out_item_t                     out_data,
	input  wire logic                               cfg_we,
	input  wire logic [lgts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [lgts_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	lgts_pkg::cmd_t cmd;
	lgts_pkg::sts_t sts;

	// Sequencer.
	lgts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Tables and arithmetic.
	lgts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
